[sv/assert_macros.svh]
// Assertion helpers for the checker file.
// Each macro takes a label and a property expression sampled on aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset.
`define ASSERT_ON(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Check a property on every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`endif

[sv/blam_pkg.sv]
package blam_pkg;

    localparam int ADDR_LINES      = 16;
    localparam int DATA_LINES      = 8;
    localparam int CTRL_LINES      = 7;
    localparam int EDGE_COUNT_BITS = 16;

    localparam int LINE_W    = 31;
    localparam int DATA_BASE = 16;
    localparam int CTRL_BASE = 24;
    localparam int RISE_W    = 8;
    localparam int WIN_W     = 24;
    localparam int TPS_W     = 27;
    localparam int HZ_W      = 32;
    localparam int PROD_W    = EDGE_COUNT_BITS + TPS_W;

    localparam int ADDR_ST_W = 32;
    localparam int DATA_ST_W = 16;
    localparam int CTRL_ST_W = 14;
    localparam int RST_ST_W  = 2;

    localparam logic [WIN_W-1:0] WINDOW_LEN_RST = WIN_W'(20000);
    localparam logic [WIN_W-1:0] GATE_LEN_RST   = WIN_W'(10000);
    localparam logic [TPS_W-1:0] TPS_RST        = TPS_W'(1000000);

    typedef enum logic [1:0] {
        CFG_WINDOW_LEN = 2'd0,
        CFG_GATE_LEN   = 2'd1,
        CFG_TPS        = 2'd2
    } cfg_idx_t;

    // Per-line status codes
    localparam logic [1:0] LINE_TOGGLING   = 2'd0;
    localparam logic [1:0] LINE_STUCK_HIGH = 2'd1;
    localparam logic [1:0] LINE_STUCK_LOW  = 2'd2;

    // Reset line state codes
    localparam logic [1:0] RST_DRIVEN   = 2'd0;
    localparam logic [1:0] RST_TOGGLING = 2'd1;
    localparam logic [1:0] RST_RELEASED = 2'd2;
    localparam logic [1:0] RST_HELD     = 2'd3;

    typedef struct packed {
        logic [ADDR_ST_W-1:0]       addr_status;
        logic [DATA_ST_W-1:0]       data_status;
        logic [CTRL_ST_W-1:0]       ctrl_status;
        logic [RST_ST_W-1:0]        reset_state;
        logic [EDGE_COUNT_BITS-1:0] edge_count;
    } blam_summary_t;

endpackage

[sv/blam_accum.sv]
module blam_accum import blam_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick_en,
    input  logic [LINE_W-1:0]    lines,
    input  logic                 reset_level,
    input  logic                 reset_driven,
    input  logic [RISE_W-1:0]    rises,
    input  logic [WIN_W-1:0]     window_len,
    input  logic [WIN_W-1:0]     gate_len,
    output logic                 win_end,
    output blam_summary_t        summary
);

    logic [LINE_W-1:0]          any_high_reg, any_high_next;
    logic [LINE_W-1:0]          any_low_reg, any_low_next;
    logic                       seen_high_reg, seen_high_next;
    logic                       seen_low_reg, seen_low_next;
    logic [EDGE_COUNT_BITS-1:0] edge_reg, edge_next;
    logic [WIN_W-1:0]           tick_reg, tick_next;
    logic [WIN_W-1:0]           win_eff;

    function automatic logic [ADDR_ST_W-1:0] group_code(
        input logic [LINE_W-1:0] hi,
        input logic [LINE_W-1:0] lo,
        input int                base,
        input int                count
    );
        logic [ADDR_ST_W-1:0] r;
        r = '0;
        for (int i = 0; i < ADDR_ST_W / 2; i++) begin
            if (i < count) begin
                if (hi[base + i] && lo[base + i]) begin
                    r[2*i +: 2] = LINE_TOGGLING;
                end else if (hi[base + i]) begin
                    r[2*i +: 2] = LINE_STUCK_HIGH;
                end else begin
                    r[2*i +: 2] = LINE_STUCK_LOW;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        any_high_next  = any_high_reg | lines;
        any_low_next   = any_low_reg | ~lines;
        seen_high_next = seen_high_reg | reset_level;
        seen_low_next  = seen_low_reg | ~reset_level;
        edge_next      = edge_reg;
        if (tick_reg < gate_len) begin
            edge_next = edge_reg + EDGE_COUNT_BITS'(rises);
        end
        tick_next = tick_reg + WIN_W'(1);
        win_eff   = (window_len == '0) ? WIN_W'(1) : window_len;
        win_end   = (tick_next >= win_eff) || (tick_next == '0);

        summary.addr_status = group_code(any_high_next, any_low_next, 0, ADDR_LINES);
        summary.data_status = DATA_ST_W'(group_code(any_high_next, any_low_next,
                                                    DATA_BASE, DATA_LINES));
        summary.ctrl_status = CTRL_ST_W'(group_code(any_high_next, any_low_next,
                                                    CTRL_BASE, CTRL_LINES));
        if (reset_driven) begin
            summary.reset_state = RST_DRIVEN;
        end else if (seen_high_next && seen_low_next) begin
            summary.reset_state = RST_TOGGLING;
        end else if (seen_high_next) begin
            summary.reset_state = RST_RELEASED;
        end else begin
            summary.reset_state = RST_HELD;
        end
        summary.edge_count = edge_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_high_reg  <= '0;
            any_low_reg   <= '0;
            seen_high_reg <= 1'b0;
            seen_low_reg  <= 1'b0;
            edge_reg      <= '0;
            tick_reg      <= '0;
        end else if (tick_en) begin
            if (win_end) begin
                any_high_reg  <= '0;
                any_low_reg   <= '0;
                seen_high_reg <= 1'b0;
                seen_low_reg  <= 1'b0;
                edge_reg      <= '0;
                tick_reg      <= '0;
            end else begin
                any_high_reg  <= any_high_next;
                any_low_reg   <= any_low_next;
                seen_high_reg <= seen_high_next;
                seen_low_reg  <= seen_low_next;
                edge_reg      <= edge_next;
                tick_reg      <= tick_next;
            end
        end
    end

endmodule

[sv/blam_hz_div.sv]
module blam_hz_div import blam_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [EDGE_COUNT_BITS-1:0] edges,
    input  logic [TPS_W-1:0]           tps,
    input  logic [WIN_W-1:0]           gate,
    input  logic                       ack,
    output logic                       busy,
    output logic                       done,
    output logic [HZ_W-1:0]            hz
);

    localparam int CNT_W = $clog2(PROD_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic [EDGE_COUNT_BITS-1:0] edges_reg;
    logic [TPS_W-1:0]           tps_reg;
    logic [WIN_W-1:0]           gate_reg;
    logic [PROD_W-1:0]          quo_reg;
    logic [WIN_W-1:0]           rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [WIN_W:0]             trial;
    logic                       fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, gate_reg};

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign hz   = (|quo_reg[PROD_W-1:HZ_W]) ? '1 : quo_reg[HZ_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        edges_reg <= edges;
                        tps_reg   <= tps;
                        gate_reg  <= gate;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(PROD_W - 1);
                    if (gate_reg == '0) begin
                        quo_reg   <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        quo_reg   <= PROD_W'(edges_reg) * PROD_W'(tps_reg);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (fits) begin
                        rem_reg <= WIN_W'(trial - {1'b0, gate_reg});
                    end else begin
                        rem_reg <= trial[WIN_W-1:0];
                    end
                    quo_reg <= {quo_reg[PROD_W-2:0], fits};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (ack) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/bus_line_activity_monitor.sv]
// Bus line activity monitor.
// Input stream: one transaction per sample tick. s_tdata carries the 31 bus
// line levels and the clock rising edges seen since the previous tick;
// s_tuser carries the reset line level and the cartridge reset-drive flag.
// Output stream: one transaction per observation window with the status of
// every address, data and control line (active, stuck high, stuck low), the
// reset line state and the measured bus clock in Hz.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// window_len (0), gate_len (1) or ticks_per_second (2); other indexes are
// dropped. Write only while the block is idle.
// Flow: ticks are taken while the unit is free. The tick that closes the
// window starts the multiply/divide unit: a multiply step, then one quotient
// bit per cycle over PROD_W (43) bits, then the done state; s_tready stays
// low until the result is loaded into the output register and raises
// m_tvalid. With a zero gate the divide is skipped and the result is 0 Hz.
// Reset (aresetn low, synchronous) clears the window accumulators, the unit
// sequencer and m_tvalid, and loads the default register values.
// Receiver stall: the result holds in the output register; ticks keep being
// taken until the next window closes, then the unit holds its result and
// s_tready stays low until the output register is free.
module bus_line_activity_monitor import blam_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Tick input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // [30:0] bus_lines, [38:31] clock_rises
    input  logic [1:0]           s_tuser,   // [0] reset_level, [1] reset_driven
    // Window result
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,   // [31:0] addr_status, [47:32] data_status,
                                            // [61:48] ctrl_status, [93:62] clock_hz
    output logic [RST_ST_W-1:0]  m_tuser,   // [1:0] reset_state
    // Register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [TPS_W-1:0]     cfg_data
);

    logic [WIN_W-1:0]     window_len_reg;
    logic [WIN_W-1:0]     gate_len_reg;
    logic [TPS_W-1:0]     tps_reg;

    logic                 tick_en;
    logic                 win_end;
    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic                 out_free;
    logic                 out_load;
    logic [HZ_W-1:0]      div_hz;
    blam_summary_t        summary;

    logic [ADDR_ST_W-1:0] addr_pend_reg;
    logic [DATA_ST_W-1:0] data_pend_reg;
    logic [CTRL_ST_W-1:0] ctrl_pend_reg;
    logic [RST_ST_W-1:0]  rst_pend_reg;
    logic                 m_tvalid_reg;
    logic [95:0]          m_tdata_reg;
    logic [RST_ST_W-1:0]  m_tuser_reg;

    // Registers are always writable; the user keeps writes to idle periods.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RST;
            gate_len_reg   <= GATE_LEN_RST;
            tps_reg        <= TPS_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_LEN: window_len_reg <= cfg_data[WIN_W-1:0];
                CFG_GATE_LEN:   gate_len_reg   <= cfg_data[WIN_W-1:0];
                CFG_TPS:        tps_reg        <= cfg_data;
                default: begin
                    // Unknown index: drop the write
                end
            endcase
        end
    end

    // Ticks are taken whenever the divide unit is free.
    assign s_tready  = !div_busy;
    assign tick_en   = s_tvalid && s_tready;
    assign div_start = tick_en && win_end;

    blam_accum u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_en      (tick_en),
        .lines        (s_tdata[LINE_W-1:0]),
        .reset_level  (s_tuser[0]),
        .reset_driven (s_tuser[1]),
        .rises        (s_tdata[LINE_W +: RISE_W]),
        .window_len   (window_len_reg),
        .gate_len     (gate_len_reg),
        .win_end      (win_end),
        .summary      (summary)
    );

    blam_hz_div u_hz_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .edges   (summary.edge_count),
        .tps     (tps_reg),
        .gate    (gate_len_reg),
        .ack     (out_free),
        .busy    (div_busy),
        .done    (div_done),
        .hz      (div_hz)
    );

    // Hold the line statuses of the closed window while the Hz value is worked out.
    always_ff @(posedge aclk) begin
        if (div_start) begin
            addr_pend_reg <= summary.addr_status;
            data_pend_reg <= summary.data_status;
            ctrl_pend_reg <= summary.ctrl_status;
            rst_pend_reg  <= summary.reset_state;
        end
    end

    // Output register: load when the unit is done and the slot is empty or draining.
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = div_done && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, div_hz, ctrl_pend_reg, data_pend_reg, addr_pend_reg};
            m_tuser_reg <= rst_pend_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[sv/blam_checker.sv]
`include "assert_macros.svh"

module blam_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds.
    `ASSERT_ON(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Reset empties the output register.
    `ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid)

    // The input stalls only after a tick was taken (the closing tick of a window).
    `ASSERT_ON(a_stall_after_tick, $fell(s_tready) |-> $past(s_tvalid && s_tready))

    // A new result is only produced by the busy divide unit.
    `ASSERT_ON(a_result_from_unit, $rose(m_tvalid) |-> $past(!s_tready))

endmodule

bind bus_line_activity_monitor blam_checker u_blam_checker (.*);

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import blam_pkg::*;

    // Cycles to let pass after the last expected window result before a register
    // write or the end of the run: the closing tick keeps the multiply/divide unit
    // busy.
    localparam int RESULT_LATENCY = 64;
    // Cycles without any transaction on any channel before the run is given up.
    localparam int WATCHDOG_LIMIT = 5000;

    // The write channel drops this index; no register sits behind it.
    localparam logic [1:0]       CFG_UNUSED = 2'd3;
    localparam logic [WIN_W-1:0] WIN_MAX    = '1;
    localparam logic [TPS_W-1:0] TPS_MAX    = '1;

    // One sample tick as seen on the input stream.
    typedef struct packed {
        logic [LINE_W-1:0] lines;
        logic              rst_level;
        logic              rst_driven;
        logic [RISE_W-1:0] rises;
    } tick_t;

    // One window result, field by field.
    typedef struct packed {
        logic [HZ_W-1:0]      hz;
        logic [RST_ST_W-1:0]  rst_state;
        logic [CTRL_ST_W-1:0] ctrl;
        logic [DATA_ST_W-1:0] data;
        logic [ADDR_ST_W-1:0] addr;
    } window_report_t;

    typedef enum logic {ROW_TICK, ROW_REG} plan_kind_t;

    // One row of the directed table: either a register write or a tick, the
    // latter with a hand-written result where it is obvious.
    typedef struct {
        plan_kind_t     kind;
        logic [1:0]     sel;
        logic [TPS_W-1:0] value;
        tick_t          tick;
        bit             typed;
        window_report_t want;
    } plan_row_t;

    // DUT ports
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;   // [30:0] bus_lines, [38:31] clock_rises
    logic [1:0]           s_tuser   = '0;   // [0] reset_level, [1] reset_driven
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [95:0]          m_tdata;          // [31:0] addr, [47:32] data, [61:48] ctrl,
                                            // [93:62] clock_hz
    logic [RST_ST_W-1:0]  m_tuser;          // [1:0] reset_state
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = CFG_WINDOW_LEN;
    logic [TPS_W-1:0]     cfg_data  = '0;

    // Register copies and window accumulators of the predictor
    logic [WIN_W-1:0]           win_len_m   = WINDOW_LEN_RST;
    logic [WIN_W-1:0]           gate_len_m  = GATE_LEN_RST;
    logic [TPS_W-1:0]           tick_rate_m = TPS_RST;
    logic [LINE_W-1:0]          seen_high   = '0;
    logic [LINE_W-1:0]          seen_low    = '0;
    logic                       rst_high_seen = 1'b0;
    logic                       rst_low_seen  = 1'b0;
    logic [EDGE_COUNT_BITS-1:0] edge_total  = '0;
    logic [WIN_W-1:0]           ticks_taken = '0;

    window_report_t pending_reports[$];
    plan_row_t      plan[$];
    int unsigned    mismatches  = 0;
    int unsigned    idle_cycles = 0;
    bit             steady      = 1'b0;   // no idling on either side while set

    // Shape of the random line levels: lines under hold_mask stay at hold_value
    // so that stuck lines show up in a window; the rest toggle freely.
    logic [LINE_W-1:0] hold_mask  = '0;
    logic [LINE_W-1:0] hold_value = '0;
    int unsigned       rst_mode   = 2;
    int unsigned       rise_lo    = 0;
    int unsigned       rise_hi    = 255;

    bus_line_activity_monitor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [1:0] line_status(int unsigned idx);
        if (seen_high[idx] && seen_low[idx]) return LINE_TOGGLING;
        if (seen_high[idx]) return LINE_STUCK_HIGH;
        return LINE_STUCK_LOW;
    endfunction

    // Fold one accepted tick into the window; return 1 and the window result
    // when this tick closes the window.
    function automatic bit observe_tick(input tick_t t, output window_report_t rep);
        logic [WIN_W-1:0] span;
        logic [63:0]      product;
        logic [63:0]      quotient;
        rep = '0;
        seen_high |= t.lines;
        seen_low  |= ~t.lines;
        if (t.rst_level) rst_high_seen = 1'b1;
        else rst_low_seen = 1'b1;
        // Edges only count in the leading gate ticks; the counter wraps.
        if (ticks_taken < gate_len_m) edge_total += t.rises;
        ticks_taken += 1'b1;
        // A zero window behaves as one tick; a window shortened below the ticks
        // already taken closes on this tick.
        span = (win_len_m == '0) ? WIN_W'(1) : win_len_m;
        if (ticks_taken < span && ticks_taken != '0) return 1'b0;

        for (int i = 0; i < ADDR_LINES; i++) rep.addr[2*i +: 2] = line_status(i);
        for (int i = 0; i < DATA_LINES; i++) rep.data[2*i +: 2] = line_status(DATA_BASE + i);
        for (int i = 0; i < CTRL_LINES; i++) rep.ctrl[2*i +: 2] = line_status(CTRL_BASE + i);

        if (t.rst_driven) rep.rst_state = RST_DRIVEN;
        else if (rst_high_seen && rst_low_seen) rep.rst_state = RST_TOGGLING;
        else if (rst_high_seen) rep.rst_state = RST_RELEASED;
        else rep.rst_state = RST_HELD;

        // Zero gate gives 0 Hz; otherwise floor division, saturated to 32 bits.
        if (gate_len_m != '0) begin
            product  = 64'(edge_total) * 64'(tick_rate_m);
            quotient = product / 64'(gate_len_m);
            rep.hz   = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[HZ_W-1:0];
        end

        seen_high     = '0;
        seen_low      = '0;
        rst_high_seen = 1'b0;
        rst_low_seen  = 1'b0;
        edge_total    = '0;
        ticks_taken   = '0;
        return 1'b1;
    endfunction

    function automatic void apply_reg(logic [1:0] sel, logic [TPS_W-1:0] value);
        case (sel)
            CFG_WINDOW_LEN: win_len_m   = value[WIN_W-1:0];
            CFG_GATE_LEN:   gate_len_m  = value[WIN_W-1:0];
            CFG_TPS:        tick_rate_m = value;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    function automatic void plan_tick(logic [LINE_W-1:0] lines, logic lvl, logic drv,
                                      logic [RISE_W-1:0] rises, bit typed = 1'b0,
                                      window_report_t want = '0);
        plan_row_t row;
        row.kind  = ROW_TICK;
        row.sel   = CFG_WINDOW_LEN;
        row.value = '0;
        row.tick  = '{lines: lines, rst_level: lvl, rst_driven: drv, rises: rises};
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_reg(logic [1:0] sel, logic [TPS_W-1:0] value);
        plan_row_t row;
        row.kind  = ROW_REG;
        row.sel   = sel;
        row.value = value;
        row.tick  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    function automatic tick_t random_tick();
        tick_t t;
        // Reshape now and then, so most windows see a steady pattern.
        if ($urandom_range(99) < 6) begin
            case ($urandom_range(3))
                0: hold_mask = '0;
                1: hold_mask = LINE_W'($urandom & $urandom);
                2: hold_mask = LINE_W'($urandom | $urandom);
                default: hold_mask = '1;
            endcase
            hold_value = LINE_W'($urandom);
            rst_mode   = $urandom_range(3);
        end
        t.lines = (LINE_W'($urandom) & ~hold_mask) | (hold_value & hold_mask);
        case (rst_mode)
            0: t.rst_level = 1'b0;
            1: t.rst_level = 1'b1;
            default: t.rst_level = 1'($urandom_range(1));
        endcase
        t.rst_driven = ($urandom_range(99) < 20);
        t.rises      = RISE_W'($urandom_range(rise_hi, rise_lo));
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: inputs change at the falling edge, handshakes are sampled at
    // the rising edge.
    // ------------------------------------------------------------------

    // Drop the tick stream and hold until every expected result has arrived.
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] sel, logic [TPS_W-1:0] value);
        wait_results_drained();
        // A closing tick may still be in the divider; let it finish.
        repeat (RESULT_LATENCY) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(sel, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(tick_t t, bit typed, window_report_t want);
        window_report_t rep;
        int unsigned    gap;
        // Idle the sender now and then.
        if (!steady && $urandom_range(99) < 5) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, t.rises, t.lines};
        s_tuser  <= {t.rst_driven, t.rst_level};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Transaction taken: advance the predictor. Rows with a hand-written
        // result are checked against that instead of the predictor's.
        if (observe_tick(t, rep)) pending_reports.push_back(typed ? want : rep);
    endtask

    // Program the three registers, then stream random ticks; halfway through,
    // hold the sender until all expected results are in.
    task automatic run_phase(logic [TPS_W-1:0] win, logic [TPS_W-1:0] gate,
                             logic [TPS_W-1:0] tps, int unsigned count,
                             int unsigned lo, int unsigned hi);
        write_reg(CFG_WINDOW_LEN, win);
        write_reg(CFG_GATE_LEN, gate);
        write_reg(CFG_TPS, tps);
        rise_lo = lo;
        rise_hi = hi;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_results_drained();
            send_tick(random_tick(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Stall the result stream about a tenth of the time, except in steady stretches.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 10);
    end

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        window_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("window result with none pending", m_tdata[31:0], '0);
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[31:0] !== want.addr)
                    flag_mismatch("addr_status", m_tdata[31:0], want.addr);
                if (m_tdata[47:32] !== want.data)
                    flag_mismatch("data_status", m_tdata[47:32], want.data);
                if (m_tdata[61:48] !== want.ctrl)
                    flag_mismatch("ctrl_status", m_tdata[61:48], want.ctrl);
                if (m_tuser !== want.rst_state)
                    flag_mismatch("reset_state", m_tuser, want.rst_state);
                if (m_tdata[93:62] !== want.hz)
                    flag_mismatch("clock_hz", m_tdata[93:62], want.hz);
            end
        end
    end

    // Count cycles in which no channel moves a transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        // Hold reset, then release it at a falling edge.
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // One-tick windows with the gate and tick rate left at their reset
        // values: 1 edge reads as 100 Hz. Bits above the 24-bit window register
        // must fall away.
        plan_reg(CFG_WINDOW_LEN, 27'h700_0001);
        // All lines low, reset held low.
        plan_tick(31'h0, 1'b0, 1'b0, 8'd0, 1'b1,
                  window_report_t'{hz: 32'd0, rst_state: RST_HELD, ctrl: 14'h2AAA,
                                   data: 16'hAAAA, addr: 32'hAAAA_AAAA});
        // All lines high, reset running, most edges per tick.
        plan_tick(31'h7FFF_FFFF, 1'b1, 1'b0, 8'd255, 1'b1,
                  window_report_t'{hz: 32'd25500, rst_state: RST_RELEASED, ctrl: 14'h1555,
                                   data: 16'h5555, addr: 32'h5555_5555});
        // Cartridge drives reset.
        plan_tick(31'h0, 1'b1, 1'b1, 8'd1, 1'b1,
                  window_report_t'{hz: 32'd100, rst_state: RST_DRIVEN, ctrl: 14'h2AAA,
                                   data: 16'hAAAA, addr: 32'hAAAA_AAAA});
        // Two-tick window with complementary levels: every line active, reset pulsing.
        plan_reg(CFG_WINDOW_LEN, 27'd2);
        plan_tick(31'h5555_5555, 1'b0, 1'b0, 8'd10);
        plan_tick(31'h2AAA_AAAA, 1'b1, 1'b0, 8'd20, 1'b1,
                  window_report_t'{hz: 32'd3000, rst_state: RST_TOGGLING, ctrl: '0,
                                   data: '0, addr: '0});
        // Zero gate reads 0 Hz; zero window acts as one tick.
        plan_reg(CFG_GATE_LEN, 27'd0);
        plan_reg(CFG_WINDOW_LEN, 27'd0);
        plan_tick(31'h7FFF_FFFF, 1'b0, 1'b0, 8'd255, 1'b1,
                  window_report_t'{hz: 32'd0, rst_state: RST_HELD, ctrl: 14'h1555,
                                   data: 16'h5555, addr: 32'h5555_5555});
        // Fastest tick rate over a one-tick gate: the Hz value saturates.
        plan_reg(CFG_GATE_LEN, 27'd1);
        plan_reg(CFG_TPS, TPS_MAX);
        plan_tick(31'h1234_5678, 1'b1, 1'b0, 8'd255);
        plan_tick(31'h6DCB_A987, 1'b0, 1'b1, 8'd1);
        // Zero tick rate reads 0 Hz.
        plan_reg(CFG_TPS, 27'd0);
        plan_tick(31'h0F0F_0F0F, 1'b1, 1'b0, 8'd200);
        // Longest window and gate, then shorten the window below the ticks
        // already taken: the next tick closes it.
        plan_reg(CFG_TPS, 27'd1);
        plan_reg(CFG_GATE_LEN, 27'(WIN_MAX));
        plan_reg(CFG_WINDOW_LEN, 27'(WIN_MAX));
        for (int i = 0; i < 5; i++)
            plan_tick(31'h3C3C_3C3C ^ (31'h1 << (6 * i)), i[0], 1'b0, 8'd255);
        plan_reg(CFG_WINDOW_LEN, 27'd3);
        plan_tick(31'h4000_0001, 1'b0, 1'b0, 8'd255);
        // Dropped register index must leave every register alone.
        plan_reg(CFG_UNUSED, 27'h5A5_A5A5);
        // Gate shorter than the window, then longer than it.
        plan_reg(CFG_GATE_LEN, 27'd2);
        plan_reg(CFG_WINDOW_LEN, 27'd5);
        plan_reg(CFG_TPS, 27'd1000);
        for (int i = 0; i < 5; i++)
            plan_tick(31'h0000_FFFF << i, 1'b1, 1'b0, 8'(40 + i));
        plan_reg(CFG_GATE_LEN, 27'd10);
        for (int i = 0; i < 5; i++)
            plan_tick(31'h7F00_00FF >> i, i[1], i == 4, 8'(250 - i));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) write_reg(plan[i].sel, plan[i].value);
            else send_tick(plan[i].tick, plan[i].typed, plan[i].want);
        end

        // Random part: short windows that close often, window zero, a steady
        // stretch with no idling, a long window that wraps the edge counter,
        // saturating rates and finally slow rates including zero.
        run_phase(TPS_W'($urandom_range(1, 4)), TPS_W'($urandom_range(1, 4)),
                  TPS_W'($urandom_range(1, TPS_MAX)), 100, 0, 255);
        run_phase(27'd0, 27'd0, TPS_W'($urandom), 40, 0, 255);
        steady = 1'b1;
        run_phase(TPS_W'($urandom_range(5, 20)), TPS_W'($urandom_range(0, 25)),
                  TPS_W'($urandom_range(1, TPS_MAX)), 150, 0, 255);
        steady = 1'b0;
        run_phase(27'd280, 27'(WIN_MAX), TPS_MAX, 300, 200, 255);
        run_phase(TPS_W'($urandom_range(2, 6)), 27'd1,
                  TPS_W'($urandom_range(100000000, TPS_MAX)), 100, 128, 255);
        run_phase(TPS_W'($urandom_range(1, 12)), TPS_W'($urandom_range(0, 12)),
                  TPS_W'($urandom_range(0, 1000)), 60, 0, 255);

        // Drain, then give any stray result time to show up.
        wait_results_drained();
        repeat (RESULT_LATENCY) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/blam_pkg.sv
sv/blam_accum.sv
sv/blam_hz_div.sv
sv/bus_line_activity_monitor.sv
sv/blam_checker.sv
bench/testbench.sv
